// ===== design/lasm_pkg.sv =====
// shared types and constants of the line aware substring matcher
package lasm_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int REG_BYTES       = 16;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_INDEX_W     = 2;
  localparam int LEN_W           = 5;
  localparam int ROW_W           = 20;
  localparam int COL_W           = 16;
  localparam int COUNT_W         = 20;

  localparam logic [7:0]         NEWLINE_BYTE = 8'h0A;
  localparam logic [ROW_W-1:0]   ROW_MAX      = '1;
  localparam logic [COL_W-1:0]   COL_MAX      = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_LENGTH    = 2'd0,
    CFG_PATTERN_WORD_LOW  = 2'd1,
    CFG_PATTERN_WORD_HIGH = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       file_start;
  } in_word_t;

  typedef struct packed {
    logic [ROW_W-1:0]   match_row;
    logic [COL_W-1:0]   match_column;
    logic [COUNT_W-1:0] matches_in_file;
  } out_word_t;

  typedef struct packed {
    logic      push;
    out_word_t word;
  } queue_wr_t;

  typedef struct packed {
    logic      pop;
  } queue_rd_t;

  typedef struct packed {
    logic      not_empty;
    out_word_t word;
  } queue_head_t;

endpackage

// ===== design/line_aware_substring_matcher.sv =====
// top level of the line aware substring matcher
//
// input side is a queue: drive in_word and raise in_push; the word is taken
// at a clock edge where in_full is low. one text byte per word, file_start
// marks the first byte of a new file and restarts row, column and count.
// result side is a queue: while out_empty is low the oldest match is on
// out_word (row, start column, running count); raise out_pop to take it.
// the user must set the pattern through cfg_wr_en / cfg_index / cfg_data
// only while idle; the block does not enforce it. index 0 length, 1 bytes
// 0 to 7, 2 bytes 8 to 15, other indexes ignored. throughput is one byte
// per cycle while in_full is low; the window compare is a combinational
// parallel compare of all window bytes in the front end. if the receiver
// stalls, matches collect in a QUEUE_DEPTH entry queue plus the output
// register; in_full rises when the queue is full and bytes wait.
// synchronous reset clears line state, counters, pattern and queues; the
// block takes words in the first cycle after reset.
module line_aware_substring_matcher #(
  parameter int PATTERN_MAX = lasm_pkg::PATTERN_MAX_DEF,
  parameter int QUEUE_DEPTH = lasm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  lasm_pkg::in_word_t               in_word,
  output logic                             out_empty,
  input  logic                             out_pop,
  output lasm_pkg::out_word_t              out_word,
  input  logic                             cfg_wr_en,
  input  logic [lasm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lasm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lasm_pkg::queue_wr_t   queue_wr;
  lasm_pkg::queue_rd_t   queue_rd;
  lasm_pkg::queue_head_t queue_head;
  logic                  queue_full;

  assign in_full = queue_full;

  lasm_front #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .queue_full (queue_full),
    .in_word    (in_word),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .queue_wr   (queue_wr)
  );

  lasm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .queue_wr   (queue_wr),
    .queue_rd   (queue_rd),
    .queue_head (queue_head),
    .full       (queue_full)
  );

  lasm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .queue_head (queue_head),
    .queue_rd   (queue_rd),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_word   (out_word)
  );

endmodule

// ===== design/lasm_front.sv =====
// front end: configuration, line tracking, window compare and result forming
module lasm_front #(
  parameter int PATTERN_MAX = lasm_pkg::PATTERN_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  input  logic                                queue_full,
  input  lasm_pkg::in_word_t                  in_word,
  input  logic                                cfg_wr_en,
  input  logic [lasm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lasm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output lasm_pkg::queue_wr_t                 queue_wr
);

  localparam int NCMP = (lasm_pkg::REG_BYTES < PATTERN_MAX) ? lasm_pkg::REG_BYTES : PATTERN_MAX;
  localparam logic [lasm_pkg::LEN_W-1:0] LEN_LIMIT = lasm_pkg::LEN_W'(NCMP);

  logic [lasm_pkg::LEN_W-1:0]      pat_len_r;
  logic [lasm_pkg::CFG_DATA_W-1:0] pat_low_r;
  logic [lasm_pkg::CFG_DATA_W-1:0] pat_high_r;

  logic [7:0]                    window_r   [NCMP];
  logic [7:0]                    window_nxt [NCMP];
  logic [lasm_pkg::ROW_W-1:0]    row_r, row_nxt;
  logic [lasm_pkg::COL_W-1:0]    col_r, col_nxt, col_base;
  logic [lasm_pkg::COUNT_W-1:0]  count_r, count_nxt, count_base;
  logic                          prev_nl_r, prev_nl_nxt;

  logic [2*lasm_pkg::CFG_DATA_W-1:0] pat_all;
  logic [NCMP-1:0]                   byte_ok;
  logic                              len_ok, col_ok, hit, accept;
  logic [lasm_pkg::LEN_W-1:0]        pat_idx [NCMP];
  logic [lasm_pkg::COL_W-1:0]        start_col;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r  <= '0;
      pat_low_r  <= '0;
      pat_high_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (lasm_pkg::cfg_index_t'(cfg_index))
        lasm_pkg::CFG_PATTERN_LENGTH:    pat_len_r  <= cfg_data[lasm_pkg::LEN_W-1:0];
        lasm_pkg::CFG_PATTERN_WORD_LOW:  pat_low_r  <= cfg_data;
        lasm_pkg::CFG_PATTERN_WORD_HIGH: pat_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept  = in_push && !queue_full;
  assign pat_all = {pat_high_r, pat_low_r};

  // line bookkeeping
  always_comb begin
    if (in_word.file_start) begin
      row_nxt    = lasm_pkg::ROW_W'(1);
      col_base   = '0;
      count_base = '0;
    end else if (prev_nl_r) begin
      row_nxt    = (row_r == lasm_pkg::ROW_MAX) ? row_r : row_r + 1'b1;
      col_base   = '0;
      count_base = count_r;
    end else begin
      row_nxt    = row_r;
      col_base   = col_r;
      count_base = count_r;
    end
    col_nxt     = (col_base == lasm_pkg::COL_MAX) ? col_base : col_base + 1'b1;
    prev_nl_nxt = (in_word.text_byte == lasm_pkg::NEWLINE_BYTE);
    window_nxt[0] = in_word.text_byte;
    for (int i = 1; i < NCMP; i++) begin
      window_nxt[i] = window_r[i-1];
    end
  end

  // window compare, newest byte against the last pattern byte
  always_comb begin
    for (int j = 0; j < NCMP; j++) begin
      pat_idx[j] = pat_len_r - 1'b1 - lasm_pkg::LEN_W'(j);
      byte_ok[j] = (lasm_pkg::LEN_W'(j) >= pat_len_r) ||
                   (window_nxt[j] == pat_all[8*pat_idx[j][3:0] +: 8]);
    end
    len_ok = (pat_len_r != '0) && (pat_len_r <= LEN_LIMIT);
    col_ok = (col_nxt >= lasm_pkg::COL_W'(pat_len_r));
    hit    = len_ok && col_ok && (&byte_ok);
    count_nxt = (hit && count_base != lasm_pkg::COUNT_MAX) ? count_base + 1'b1 : count_base;
    start_col = (col_nxt == lasm_pkg::COL_MAX) ? lasm_pkg::COL_MAX
              : col_nxt - lasm_pkg::COL_W'(pat_len_r) + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= lasm_pkg::ROW_W'(1);
      col_r     <= '0;
      count_r   <= '0;
      prev_nl_r <= 1'b0;
      for (int i = 0; i < NCMP; i++) begin
        window_r[i] <= '0;
      end
    end else if (accept) begin
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      count_r   <= count_nxt;
      prev_nl_r <= prev_nl_nxt;
      for (int i = 0; i < NCMP; i++) begin
        window_r[i] <= window_nxt[i];
      end
    end
  end

  always_comb begin
    queue_wr.push                 = accept && hit;
    queue_wr.word.match_row       = row_nxt;
    queue_wr.word.match_column    = start_col;
    queue_wr.word.matches_in_file = count_nxt;
  end

endmodule

// ===== design/lasm_queue.sv =====
// small result queue between front and back
module lasm_queue #(
  parameter int DEPTH = lasm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lasm_pkg::queue_wr_t   queue_wr,
  input  lasm_pkg::queue_rd_t   queue_rd,
  output lasm_pkg::queue_head_t queue_head,
  output logic                  full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lasm_pkg::out_word_t entry_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign do_push = queue_wr.push && !full;
  assign do_pop  = queue_rd.pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= queue_wr.word;
    end
  end

  always_comb begin
    queue_head.not_empty = (count_r != '0);
    queue_head.word      = entry_r[rd_ptr_r];
  end

endmodule

// ===== design/lasm_back.sv =====
// back end: output register that drains the queue toward the receiver
module lasm_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lasm_pkg::queue_head_t queue_head,
  output lasm_pkg::queue_rd_t   queue_rd,
  output logic                  out_empty,
  input  logic                  out_pop,
  output lasm_pkg::out_word_t   out_word
);

  logic                valid_r, valid_nxt;
  lasm_pkg::out_word_t word_r;
  logic                load;

  assign load      = queue_head.not_empty && (!valid_r || out_pop);
  assign valid_nxt = load || (valid_r && !out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= queue_head.word;
    end
  end

  assign queue_rd.pop = load;
  assign out_empty    = !valid_r;
  assign out_word     = word_r;

endmodule
